// File: rtl/stok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stok_pkg
// shared types, token codes, limits and character helpers of the tokenizer
// ----------------------------------------------------------------------------
package stok_pkg;

    // limits on text length
    localparam int MAX_STRING_CHARS = 1024;
    localparam int MAX_IDENT_CHARS  = 64;

    // field widths
    localparam int KIND_W = 6;
    localparam int NUM_W  = 31;
    localparam int CNT_W  = 10;
    localparam int ERR_W  = 2;
    localparam int CAND_W = 6;

    localparam logic [NUM_W-1:0] NUM_MAX = '1;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // token kinds
    localparam logic [KIND_W-1:0] K_TEXT    = 6'd0;
    localparam logic [KIND_W-1:0] K_GT      = 6'd16;
    localparam logic [KIND_W-1:0] K_GTE     = 6'd17;
    localparam logic [KIND_W-1:0] K_LT      = 6'd18;
    localparam logic [KIND_W-1:0] K_LTE     = 6'd19;
    localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd20;
    localparam logic [KIND_W-1:0] K_EQUALS  = 6'd21;
    localparam logic [KIND_W-1:0] K_NUMBER  = 6'd22;
    localparam logic [KIND_W-1:0] K_STRING  = 6'd23;
    localparam logic [KIND_W-1:0] K_IDENT   = 6'd24;
    localparam logic [KIND_W-1:0] K_KEY0    = 6'd25;
    localparam logic [KIND_W-1:0] K_EOF     = 6'd31;
    localparam logic [KIND_W-1:0] K_ERROR   = 6'd32;

    // error codes
    localparam logic [ERR_W-1:0] E_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] E_UNTERM     = 2'd1;
    localparam logic [ERR_W-1:0] E_STR_LONG   = 2'd2;
    localparam logic [ERR_W-1:0] E_IDENT_LONG = 2'd3;

    // characters with a special role
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_marker;
    } src_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [NUM_W-1:0]  number_value;
        logic [7:0]        text_char;
        logic [CNT_W-1:0]  text_length;
        logic [ERR_W-1:0]  error_code;
        logic              last;
    } tok_req_t;

    // up to two results from one source byte
    typedef struct packed {
        logic [1:0] n;
        tok_req_t   item0;
        tok_req_t   item1;
    } push_t;

    function automatic tok_req_t mk_item(input logic [KIND_W-1:0] kind,
                                         input logic [NUM_W-1:0]  num,
                                         input logic [7:0]        ch,
                                         input logic [CNT_W-1:0]  len,
                                         input logic [ERR_W-1:0]  err);
        tok_req_t r;
        r.token_kind   = kind;
        r.number_value = num;
        r.text_char    = ch;
        r.text_length  = len;
        r.error_code   = err;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // single-character punctuation, zero when not punctuation
    function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            8'h3B:   k = 6'd1;   // ;
            8'h28:   k = 6'd2;   // (
            8'h29:   k = 6'd3;   // )
            8'h7B:   k = 6'd4;   // {
            8'h7D:   k = 6'd5;   // }
            8'h2C:   k = 6'd6;   // ,
            8'h2E:   k = 6'd7;   // .
            8'h2B:   k = 6'd8;   // +
            8'h2D:   k = 6'd9;   // -
            8'h2A:   k = 6'd10;  // *
            8'h2F:   k = 6'd11;  // /
            8'h26:   k = 6'd12;  // &
            8'h7C:   k = 6'd13;  // |
            8'h21:   k = 6'd14;  // !
            8'h40:   k = 6'd15;  // @
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic ends_ident(input logic [7:0] c);
        return is_space(c) || (punct_kind(c) != '0) || (c == CH_LT) || (c == CH_GT)
            || (c == CH_EQ) || (c == CH_QUOTE);
    endfunction

    // keyword table: while if else def var lambda
    function automatic logic [2:0] kw_len(input logic [2:0] idx);
        logic [2:0] l;
        case (idx)
            3'd0:    l = 3'd5;
            3'd1:    l = 3'd2;
            3'd2:    l = 3'd4;
            3'd3:    l = 3'd3;
            3'd4:    l = 3'd3;
            3'd5:    l = 3'd6;
            default: l = 3'd0;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] idx, input logic [2:0] pos);
        logic [47:0] w;
        logic [47:0] s;
        logic [2:0]  sh;
        case (idx)
            3'd0:    w = 48'("while");
            3'd1:    w = 48'("if");
            3'd2:    w = 48'("else");
            3'd3:    w = 48'("def");
            3'd4:    w = 48'("var");
            3'd5:    w = 48'("lambda");
            default: w = '0;
        endcase
        // first character sits in the most significant used byte
        sh = kw_len(idx) - 3'd1 - pos;
        s  = w >> {sh, 3'b000};
        return s[7:0];
    endfunction

    // drop candidates that cannot match character c at position pos
    function automatic logic [CAND_W-1:0] kw_filter(input logic [CAND_W-1:0] cand,
                                                    input logic [CNT_W-1:0]  pos,
                                                    input logic [7:0]        c);
        logic [CAND_W-1:0] r;
        r = cand;
        for (int i = 0; i < CAND_W; i++) begin
            if (pos >= CNT_W'(kw_len(3'(i))) || kw_char(3'(i), pos[2:0]) != c) begin
                r[i] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [KIND_W-1:0] kw_kind(input logic [CAND_W-1:0] cand,
                                                  input logic [CNT_W-1:0]  len);
        logic [KIND_W-1:0] k;
        k = K_IDENT;
        for (int i = 0; i < CAND_W; i++) begin
            if (cand[i] && len == CNT_W'(kw_len(3'(i)))) begin
                k = K_KEY0 + KIND_W'(i);
            end
        end
        return k;
    endfunction

endpackage
`default_nettype wire

// File: rtl/stok_lexer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stok_lexer
// lexer state and the single-pass step logic for one source byte
// ----------------------------------------------------------------------------
module stok_lexer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire stok_pkg::src_req_t req,
    output stok_pkg::push_t        push
);
    import stok_pkg::*;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_NUM     = 4'd1;
    localparam logic [3:0] M_IDENT   = 4'd2;
    localparam logic [3:0] M_STR     = 4'd3;
    localparam logic [3:0] M_ESC     = 4'd4;
    localparam logic [3:0] M_COMMENT = 4'd5;
    localparam logic [3:0] M_GT      = 4'd6;
    localparam logic [3:0] M_LT      = 4'd7;
    localparam logic [3:0] M_EQ      = 4'd8;
    localparam logic [3:0] M_HALT    = 4'd9;

    localparam logic [CNT_W-1:0] STR_LIMIT   = CNT_W'(MAX_STRING_CHARS - 1);
    localparam logic [CNT_W-1:0] IDENT_LIMIT = CNT_W'(MAX_IDENT_CHARS - 1);

    logic [3:0]        mode_reg, mode_next;
    logic [NUM_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CAND_W-1:0] cand_reg, cand_next;

    logic [7:0]        c;
    logic              fin;

    // outcome of lexing the byte from between tokens
    logic              idle_emit;
    tok_req_t          idle_item;
    logic [3:0]        idle_mode;
    logic              idle_set_acc, idle_set_cnt, idle_set_cand;
    logic [NUM_W-1:0]  idle_acc;
    logic [CNT_W-1:0]  idle_cnt;
    logic [CAND_W-1:0] idle_cand;

    logic [NUM_W+3:0]  prod;
    logic [7:0]        str_c;
    logic              run_idle;
    logic              str_emit;
    tok_req_t          r0, r1;
    logic [1:0]        n;

    assign c   = req.byte_in;
    assign fin = req.end_marker;

    always_comb
    begin
        idle_emit     = 1'b0;
        idle_item     = mk_item(K_TEXT, '0, '0, '0, E_NONE);
        idle_mode     = M_IDLE;
        idle_set_acc  = 1'b0;
        idle_set_cnt  = 1'b0;
        idle_set_cand = 1'b0;
        idle_acc      = NUM_W'(c - CH_ZERO);
        idle_cnt      = '0;
        idle_cand     = kw_filter('1, '0, c);
        if (fin)
        begin
            idle_emit = 1'b1;
            idle_item = mk_item(K_EOF, '0, '0, '0, E_NONE);
        end
        else if (is_space(c))
        begin
            idle_mode = M_IDLE;
        end
        else if (c == CH_HASH)
        begin
            idle_mode = M_COMMENT;
        end
        else if (punct_kind(c) != '0)
        begin
            idle_emit = 1'b1;
            idle_item = mk_item(punct_kind(c), '0, '0, '0, E_NONE);
        end
        else if (c == CH_GT)
        begin
            idle_mode = M_GT;
        end
        else if (c == CH_LT)
        begin
            idle_mode = M_LT;
        end
        else if (c == CH_EQ)
        begin
            idle_mode = M_EQ;
        end
        else if (is_digit(c))
        begin
            idle_mode    = M_NUM;
            idle_set_acc = 1'b1;
        end
        else if (c == CH_QUOTE)
        begin
            idle_mode    = M_STR;
            idle_set_cnt = 1'b1;
        end
        else
        begin
            // identifier start, first character goes out at once
            idle_mode     = M_IDENT;
            idle_set_cnt  = 1'b1;
            idle_cnt      = CNT_W'(1);
            idle_set_cand = 1'b1;
            idle_emit     = 1'b1;
            idle_item     = mk_item(K_TEXT, '0, c, '0, E_NONE);
        end
    end

    always_comb
    begin
        prod = (NUM_W+4)'({acc_reg, 3'b000}) + (NUM_W+4)'({acc_reg, 1'b0})
             + (NUM_W+4)'(c - CH_ZERO);
        str_c     = (mode_reg == M_ESC && c == CH_LOW_N) ? CH_NL : c;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        cand_next = cand_reg;
        r0        = mk_item(K_TEXT, '0, '0, '0, E_NONE);
        r1        = mk_item(K_TEXT, '0, '0, '0, E_NONE);
        n         = 2'd0;
        run_idle  = 1'b0;
        str_emit  = 1'b0;

        case (mode_reg)
            M_HALT:
            begin
                mode_next = M_HALT;
            end
            M_COMMENT:
            begin
                if (fin)
                begin
                    run_idle = 1'b1;
                end
                else if (c == CH_NL)
                begin
                    mode_next = M_IDLE;
                end
            end
            M_GT, M_LT, M_EQ:
            begin
                if (!fin && c == CH_EQ)
                begin
                    r0        = mk_item((mode_reg == M_GT) ? K_GTE :
                                        (mode_reg == M_LT) ? K_LTE : K_EQUALS,
                                        '0, '0, '0, E_NONE);
                    n         = 2'd1;
                    mode_next = M_IDLE;
                end
                else
                begin
                    r0       = mk_item((mode_reg == M_GT) ? K_GT :
                                       (mode_reg == M_LT) ? K_LT : K_ASSIGN,
                                       '0, '0, '0, E_NONE);
                    n        = 2'd1;
                    run_idle = 1'b1;
                end
            end
            M_NUM:
            begin
                if (!fin && is_digit(c))
                begin
                    acc_next = (prod > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : prod[NUM_W-1:0];
                end
                else
                begin
                    r0       = mk_item(K_NUMBER, acc_reg, '0, '0, E_NONE);
                    n        = 2'd1;
                    acc_next = '0;
                    run_idle = 1'b1;
                end
            end
            M_IDENT:
            begin
                if (fin || ends_ident(c))
                begin
                    r0       = mk_item(kw_kind(cand_reg, cnt_reg), '0, '0, cnt_reg, E_NONE);
                    n        = 2'd1;
                    run_idle = 1'b1;
                end
                else if (cnt_reg >= IDENT_LIMIT)
                begin
                    r0        = mk_item(K_ERROR, '0, '0, '0, E_IDENT_LONG);
                    n         = 2'd1;
                    mode_next = M_HALT;
                end
                else
                begin
                    cand_next = kw_filter(cand_reg, cnt_reg, c);
                    r0        = mk_item(K_TEXT, '0, c, '0, E_NONE);
                    n         = 2'd1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            M_STR:
            begin
                if (fin)
                begin
                    r0        = mk_item(K_ERROR, '0, '0, '0, E_UNTERM);
                    n         = 2'd1;
                    mode_next = M_HALT;
                end
                else if (c == CH_QUOTE)
                begin
                    r0        = mk_item(K_STRING, '0, '0, cnt_reg, E_NONE);
                    n         = 2'd1;
                    mode_next = M_IDLE;
                end
                else if (c == CH_BSLASH)
                begin
                    mode_next = M_ESC;
                end
                else
                begin
                    str_emit = 1'b1;
                end
            end
            M_ESC:
            begin
                if (fin)
                begin
                    r0        = mk_item(K_ERROR, '0, '0, '0, E_UNTERM);
                    n         = 2'd1;
                    mode_next = M_HALT;
                end
                else
                begin
                    str_emit = 1'b1;
                end
            end
            default:
            begin
                run_idle = 1'b1;
            end
        endcase

        // one string character, escaped or plain
        if (str_emit)
        begin
            n = 2'd1;
            if (cnt_reg >= STR_LIMIT)
            begin
                r0        = mk_item(K_ERROR, '0, '0, '0, E_STR_LONG);
                mode_next = M_HALT;
            end
            else
            begin
                r0        = mk_item(K_TEXT, '0, str_c, '0, E_NONE);
                cnt_next  = cnt_reg + CNT_W'(1);
                mode_next = M_STR;
            end
        end

        // the byte is lexed afresh after a closed token
        if (run_idle)
        begin
            mode_next = idle_mode;
            if (idle_set_acc)
            begin
                acc_next = idle_acc;
            end
            if (idle_set_cnt)
            begin
                cnt_next = idle_cnt;
            end
            if (idle_set_cand)
            begin
                cand_next = idle_cand;
            end
            if (idle_emit)
            begin
                if (n == 2'd0)
                begin
                    r0 = idle_item;
                end
                else
                begin
                    r1 = idle_item;
                end
                n = n + 2'd1;
            end
        end

        r0.last = (n == 2'd1);
        r1.last = (n == 2'd2);
    end

    assign push.n     = step ? n : 2'd0;
    assign push.item0 = r0;
    assign push.item1 = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            cand_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            cand_reg <= cand_next;
        end
    end

    // halt holds until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_HALT |=> mode_reg == M_HALT)
        else $error("lexer left halt without reset");

    // no results once halted
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_HALT |-> push.n == 2'd0)
        else $error("lexer produced results while halted");

    // an error is always the only result of its byte
    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd2 |-> (push.item0.token_kind != K_ERROR
                            && push.item1.token_kind != K_ERROR && push.item1.last))
        else $error("error result paired with another result");

endmodule
`default_nettype wire

// File: rtl/stok_result_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stok_result_queue
// small result queue taking up to two results a cycle, one out a cycle while tok_stall is low
// ----------------------------------------------------------------------------
module stok_result_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire stok_pkg::push_t    push,
    output logic                    room,
    output logic                    tok_valid,
    input  wire logic               tok_stall,
    output stok_pkg::tok_req_t      tok_req
);
    import stok_pkg::*;

    tok_req_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;

    assign tok_valid = (count_reg != '0);
    assign tok_req   = entry_reg[rd_ptr_reg];
    assign pop       = tok_valid && !tok_stall;
    // room for the worst case of two results
    assign room      = (count_reg <= QCNT_W'(QDEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.n) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.item0;
        end
        if (push.n == 2'd2)
        begin
            entry_reg[wr_ptr_reg + QPTR_W'(1)] <= push.item1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> (count_reg + QCNT_W'(push.n)) <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue count out of range");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0])
        else $error("result queue pointers disagree with count");

endmodule
`default_nettype wire

// File: rtl/source_tokenizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_tokenizer_core
// byte-serial source tokenizer with a four-entry result queue
// ----------------------------------------------------------------------------
// One source byte (or an end marker) per request on src; tokens and streamed
// identifier or string characters leave as requests on tok. A byte is taken
// into an input register, lexed against the lexer state and its zero, one or
// two results are written into a four-entry result queue, from which each
// result is offered on tok. The sustained rate is one byte per cycle while
// the queue drains a request per cycle. A byte that closes a token and starts
// another (e.g. "x;" or "a<b") yields two results; the queue absorbs two such
// surplus results, and each further two-result byte before a byte with no
// result has drained the surplus makes the source stall. The input register
// holds back (src_stall) whenever it holds a byte and the queue lacks room
// for two results. After an error result the lexer halts: bytes are still
// taken but nothing comes out until reset. No clearing pass after reset.
// ----------------------------------------------------------------------------
module source_tokenizer_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_stall,
    input  wire stok_pkg::src_req_t src_req,
    output logic                    tok_valid,
    input  wire logic               tok_stall,
    output stok_pkg::tok_req_t      tok_req
);
    import stok_pkg::*;

    // input register
    logic     in_vld_reg, in_vld_next;
    src_req_t in_req_reg;

    logic     room;
    logic     advance;
    logic     accept;
    push_t    push;

    // the held byte moves on when the queue can take its results
    assign advance   = in_vld_reg && room;
    assign src_stall = in_vld_reg && !room;
    assign accept    = src_valid && !src_stall;

    always_comb
    begin
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_req_reg <= src_req;
        end
    end

    // lexer: state plus single-pass step logic
    stok_lexer u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .req   (in_req_reg),
        .push  (push)
    );

    // result queue towards tok
    stok_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_req   (tok_req)
    );

endmodule
`default_nettype wire

// File: dv/source_tokenizer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_tokenizer_core_test
// self-checking bench for the byte-serial tokenizer: a short table of probe
// bytes, then token-shaped random source text under four idle and stall
// mixes, closed by one randomly chosen fatal error and a few ignored bytes
// ----------------------------------------------------------------------------
module source_tokenizer_core_test;
    import stok_pkg::*;

    localparam int TOTAL_ITEMS  = 1350;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;
    localparam int KW_COUNT     = 6;
    localparam int PROBE_COUNT  = 25;

    // idle and stall mix per phase, in percent
    localparam int PHASE_IDLE  [4] = '{0, 45, 0, 24};
    localparam int PHASE_STALL [4] = '{0, 0, 45, 24};

    localparam logic [KIND_W-1:0] K_KW_IF = K_KEY0 + 6'd1;

    localparam logic [7:0] PUNCT_SET [15] = '{";", "(", ")", "{", "}", ",", ".",
                                              "+", "-", "*", "/", "&", "|", "!", "@"};
    localparam logic [7:0] KW_TEXT [KW_COUNT][6] = '{
        '{"w", "h", "i", "l", "e", 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"d", "e", "f", 8'h00, 8'h00, 8'h00},
        '{"v", "a", "r", 8'h00, 8'h00, 8'h00},
        '{"l", "a", "m", "b", "d", "a"}
    };
    localparam int KW_LEN [KW_COUNT] = '{5, 2, 4, 3, 3, 6};

    typedef enum logic [3:0] {
        LX_IDLE, LX_NUM, LX_WORD, LX_STR, LX_ESC, LX_NOTE, LX_GT, LX_LT, LX_EQ, LX_HALT
    } lex_mode_e;

    typedef struct packed {
        lex_mode_e         mode;
        logic [NUM_W-1:0]  acc;
        logic [CNT_W-1:0]  cnt;
        logic [CAND_W-1:0] cand;
    } lex_state_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       typed;
        tok_req_t   want;
    } probe_row_t;

    // results that can be read straight off the token rules
    localparam tok_req_t NO_TOK      = '0;
    localparam tok_req_t EOF_TOK     = '{K_EOF, 31'd0, 8'd0, 10'd0, E_NONE, 1'b1};
    localparam tok_req_t GTE_TOK     = '{K_GTE, 31'd0, 8'd0, 10'd0, E_NONE, 1'b1};
    localparam tok_req_t EQUALS_TOK  = '{K_EQUALS, 31'd0, 8'd0, 10'd0, E_NONE, 1'b1};
    localparam tok_req_t IDENT2_TOK  = '{K_IDENT, 31'd0, 8'd0, 10'd2, E_NONE, 1'b1};
    localparam tok_req_t STRING2_TOK = '{K_STRING, 31'd0, 8'd0, 10'd2, E_NONE, 1'b1};
    localparam tok_req_t IF_TOK      = '{K_KW_IF, 31'd0, 8'd0, 10'd2, E_NONE, 1'b1};

    // probe table: typed rows carry their one result, the rest go through the predictor
    localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
        '{8'h00,     1'b1, 1'b1, EOF_TOK},      // end straight after reset
        '{CH_HASH,   1'b0, 1'b0, NO_TOK},
        '{8'hFF,     1'b0, 1'b0, NO_TOK},       // swallowed by the comment
        '{8'h00,     1'b1, 1'b1, EOF_TOK},      // end inside a comment
        '{CH_GT,     1'b0, 1'b0, NO_TOK},
        '{CH_EQ,     1'b0, 1'b1, GTE_TOK},
        '{CH_LT,     1'b0, 1'b0, NO_TOK},
        '{8'h00,     1'b0, 1'b0, NO_TOK},       // lt, then zero byte opens a word
        '{8'hFF,     1'b0, 1'b0, NO_TOK},
        '{CH_QUOTE,  1'b0, 1'b1, IDENT2_TOK},   // quote ends the word, opens a string
        '{CH_BSLASH, 1'b0, 1'b0, NO_TOK},
        '{CH_LOW_N,  1'b0, 1'b0, NO_TOK},       // escaped newline
        '{CH_BSLASH, 1'b0, 1'b0, NO_TOK},
        '{CH_QUOTE,  1'b0, 1'b0, NO_TOK},       // escaped quote
        '{CH_QUOTE,  1'b0, 1'b1, STRING2_TOK},
        '{"i",       1'b0, 1'b0, NO_TOK},
        '{"f",       1'b0, 1'b0, NO_TOK},
        '{CH_EQ,     1'b0, 1'b1, IF_TOK},
        '{CH_EQ,     1'b0, 1'b1, EQUALS_TOK},
        '{"4",       1'b0, 1'b0, NO_TOK},
        '{"2",       1'b0, 1'b0, NO_TOK},
        '{";",       1'b0, 1'b0, NO_TOK},       // number and semicolon together
        '{CH_EQ,     1'b0, 1'b0, NO_TOK},
        '{8'hFF,     1'b1, 1'b0, NO_TOK},       // assign then eof, byte ignored
        '{8'h5A,     1'b1, 1'b1, EOF_TOK}
    };

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     src_valid = 1'b0;
    logic     src_stall;
    src_req_t src_req   = '0;
    logic     tok_valid;
    logic     tok_stall = 1'b0;
    tok_req_t tok_req;

    // predictor state and the results of its latest step
    lex_state_t lx = '0;
    tok_req_t   lx_res [2];
    int         lx_n;

    tok_req_t tok_expected [$];
    tok_req_t tok_want;
    int       mismatches   = 0;
    int       items_sent   = 0;
    int       idle_pct     = 0;
    int       stall_pct    = 0;
    int       cycle_count  = 0;
    logic     guard_errors = 1'b1;

    // closing error and the random share left beside the probes and the close
    logic [ERR_W-1:0] fatal_err     = E_UNTERM;
    int               random_budget = 0;

    source_tokenizer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_req   (src_req),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_req   (tok_req)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // character classes
    // ------------------------------------------------------------------------
    function automatic logic blank_char(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [KIND_W-1:0] punct_code(input logic [7:0] c);
        for (int i = 0; i < 15; i++)
        begin
            if (PUNCT_SET[i] == c)
            begin
                return KIND_W'(i + 1);
            end
        end
        return '0;
    endfunction

    function automatic logic stops_word(input logic [7:0] c);
        return blank_char(c) || punct_code(c) != '0 || c == CH_LT || c == CH_GT
            || c == CH_EQ || c == CH_QUOTE;
    endfunction

    // ------------------------------------------------------------------------
    // lexer predictor
    // ------------------------------------------------------------------------
    function void tok_push(input logic [KIND_W-1:0] kind, input logic [NUM_W-1:0] num,
                           input logic [7:0] ch, input logic [CNT_W-1:0] len,
                           input logic [ERR_W-1:0] err);
        if (lx_n < 2)
        begin
            lx_res[lx_n] = '{kind, num, ch, len, err, 1'b0};
            lx_n++;
        end
    endfunction

    function void fail_with(input logic [ERR_W-1:0] err);
        tok_push(K_ERROR, '0, '0, '0, err);
        lx.mode = LX_HALT;
    endfunction

    function void word_char(input logic [7:0] c);
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (int'(lx.cnt) >= KW_LEN[i] || KW_TEXT[i][lx.cnt[2:0]] != c)
            begin
                lx.cand[i] = 1'b0;
            end
        end
        tok_push(K_TEXT, '0, c, '0, E_NONE);
        lx.cnt++;
    endfunction

    function void close_word();
        logic [KIND_W-1:0] kind;
        kind = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (lx.cand[i] && int'(lx.cnt) == KW_LEN[i])
            begin
                kind = K_KEY0 + KIND_W'(i);
            end
        end
        tok_push(kind, '0, '0, lx.cnt, E_NONE);
        lx.mode = LX_IDLE;
    endfunction

    function void str_char(input logic [7:0] c);
        if (int'(lx.cnt) + 1 >= MAX_STRING_CHARS)
        begin
            fail_with(E_STR_LONG);
        end
        else
        begin
            tok_push(K_TEXT, '0, c, '0, E_NONE);
            lx.cnt++;
            lx.mode = LX_STR;
        end
    endfunction

    // a byte seen between tokens
    function void lex_fresh(input logic [7:0] c, input logic fin);
        logic [KIND_W-1:0] pk;
        pk = punct_code(c);
        lx.mode = LX_IDLE;
        if (fin)
            tok_push(K_EOF, '0, '0, '0, E_NONE);
        else if (c == CH_HASH)
            lx.mode = LX_NOTE;
        else if (pk != '0)
            tok_push(pk, '0, '0, '0, E_NONE);
        else if (c == CH_GT)
            lx.mode = LX_GT;
        else if (c == CH_LT)
            lx.mode = LX_LT;
        else if (c == CH_EQ)
            lx.mode = LX_EQ;
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            lx.acc  = NUM_W'(c - CH_ZERO);
            lx.mode = LX_NUM;
        end
        else if (c == CH_QUOTE)
        begin
            lx.cnt  = '0;
            lx.mode = LX_STR;
        end
        else if (!blank_char(c))
        begin
            lx.cnt  = '0;
            lx.cand = '1;
            lx.mode = LX_WORD;
            word_char(c);
        end
    endfunction

    function void lex_step(input logic [7:0] c, input logic fin);
        logic [KIND_W-1:0] base;
        logic [63:0]       sum;
        lx_n = 0;
        case (lx.mode)
            LX_HALT:
                lx_n = 0;
            LX_NOTE:
                if (fin)
                    lex_fresh(c, fin);
                else if (c == CH_NL)
                    lx.mode = LX_IDLE;
            LX_GT, LX_LT, LX_EQ:
            begin
                base = (lx.mode == LX_GT) ? K_GT : (lx.mode == LX_LT) ? K_LT : K_ASSIGN;
                if (!fin && c == CH_EQ)
                begin
                    tok_push(base + 6'd1, '0, '0, '0, E_NONE);
                    lx.mode = LX_IDLE;
                end
                else
                begin
                    tok_push(base, '0, '0, '0, E_NONE);
                    lex_fresh(c, fin);
                end
            end
            LX_NUM:
                if (!fin && c >= CH_ZERO && c <= CH_NINE)
                begin
                    // saturate rather than wrap
                    sum    = 64'(lx.acc) * 64'd10 + 64'(c - CH_ZERO);
                    lx.acc = (sum > 64'(NUM_MAX)) ? NUM_MAX : sum[NUM_W-1:0];
                end
                else
                begin
                    tok_push(K_NUMBER, lx.acc, '0, '0, E_NONE);
                    lx.acc = '0;
                    lex_fresh(c, fin);
                end
            LX_WORD:
                if (fin || stops_word(c))
                begin
                    close_word();
                    lex_fresh(c, fin);
                end
                else if (int'(lx.cnt) + 1 >= MAX_IDENT_CHARS)
                    fail_with(E_IDENT_LONG);
                else
                    word_char(c);
            LX_STR:
                if (fin)
                    fail_with(E_UNTERM);
                else if (c == CH_QUOTE)
                begin
                    tok_push(K_STRING, '0, '0, lx.cnt, E_NONE);
                    lx.mode = LX_IDLE;
                end
                else if (c == CH_BSLASH)
                    lx.mode = LX_ESC;
                else
                    str_char(c);
            LX_ESC:
                if (fin)
                    fail_with(E_UNTERM);
                else
                    str_char((c == CH_LOW_N) ? CH_NL : c);
            default:
                lex_fresh(c, fin);
        endcase
        if (lx_n > 0)
        begin
            lx_res[lx_n-1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------------
    // predict, then hold the request until taken; while guard_errors is set a
    // byte that would halt the lexer is swapped for a space in a word, else a quote
    task automatic send_byte(input logic [7:0] ch, input logic fin, input logic typed,
                             input tok_req_t want);
        lex_state_t saved;
        int         gap;
        saved = lx;
        lex_step(ch, fin);
        if (guard_errors && lx.mode == LX_HALT)
        begin
            lx  = saved;
            ch  = (saved.mode == LX_WORD) ? 8'h20 : CH_QUOTE;
            fin = 1'b0;
            lex_step(ch, fin);
        end
        if (typed)
            tok_expected.push_back(want);
        else
            for (int i = 0; i < lx_n; i++)
                tok_expected.push_back(lx_res[i]);
        items_sent++;

        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            src_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        src_valid          = 1'b1;
        src_req.byte_in    = ch;
        src_req.end_marker = fin;
        forever
        begin
            @(posedge clk);
            if (!src_stall)
                break;
        end
    endtask

    task automatic feed(input logic [7:0] ch);
        send_byte(ch, 1'b0, 1'b0, NO_TOK);
    endtask

    function automatic logic [7:0] word_byte(input logic first);
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0)
            return 8'("a") + 8'($urandom_range(0, 25));
        do
            c = 8'($urandom);
        while (stops_word(c) || (first && (c == CH_HASH || (c >= CH_ZERO && c <= CH_NINE))));
        return c;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    // rough number of bytes the closing error sequence sends
    function automatic int closing_cost(input logic [ERR_W-1:0] err);
        int n;
        case (err)
            E_STR_LONG:   n = MAX_STRING_CHARS + 8;
            E_IDENT_LONG: n = MAX_IDENT_CHARS + 8;
            default:      n = 12;
        endcase
        return n;
    endfunction

    // one token-shaped burst of source text, with some noise mixed in
    task automatic random_token();
        int         pick;
        int         len;
        int         kw;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                // keyword, sometimes cut short or run on
                kw  = $urandom_range(0, KW_COUNT - 1);
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, KW_LEN[kw]) : KW_LEN[kw];
                for (int i = 0; i < len; i++)
                    feed(KW_TEXT[kw][i]);
                if ($urandom_range(0, 4) == 0)
                    feed(word_byte(1'b0));
            end
            else
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(56, MAX_IDENT_CHARS - 1)
                                                   : $urandom_range(1, 8);
                feed(word_byte(1'b1));
                for (int i = 1; i < len; i++)
                    feed(word_byte(1'b0));
            end
        end
        else if (pick < 40)
        begin
            // long runs push the value into saturation
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                feed(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        else if (pick < 52)
        begin
            feed(CH_QUOTE);
            len = $urandom_range(0, 10);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    feed(CH_BSLASH);
                    feed($urandom_range(0, 1) ? CH_LOW_N : 8'($urandom));
                end
                else
                    feed(text_byte());
            end
            feed(CH_QUOTE);
        end
        else if (pick < 67)
            feed(PUNCT_SET[$urandom_range(0, 14)]);
        else if (pick < 77)
        begin
            c = $urandom_range(0, 2) == 0 ? CH_GT : $urandom_range(0, 1) ? CH_LT : CH_EQ;
            feed(c);
            if ($urandom_range(0, 1))
                feed(CH_EQ);
        end
        else if (pick < 85)
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                feed($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)));
        end
        else if (pick < 89)
        begin
            feed(CH_HASH);
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++)
            begin
                do
                    c = 8'($urandom);
                while (c == CH_NL);
                feed(c);
            end
            if ($urandom_range(0, 3) != 0)
                feed(CH_NL);
            else
                send_byte(8'($urandom), 1'b1, 1'b0, NO_TOK);
        end
        else if (pick < 92)
            send_byte(8'($urandom), 1'b1, 1'b0, NO_TOK);
        else
            feed(8'($urandom));
    endtask

    // back to idle, then one fatal error; the bytes after it must come to nothing
    task automatic close_with_error(input logic [ERR_W-1:0] err);
        tok_req_t want;
        while (lx.mode != LX_IDLE)
        begin
            case (lx.mode)
                LX_STR:  feed(CH_QUOTE);
                LX_ESC:  feed("x");
                LX_NOTE: feed(CH_NL);
                default: feed(8'h20);
            endcase
        end
        guard_errors    = 1'b0;
        want            = '{K_ERROR, 31'd0, 8'd0, 10'd0, E_NONE, 1'b1};
        want.error_code = err;
        case (want.error_code)
            E_UNTERM:
            begin
                feed(CH_QUOTE);
                feed(text_byte());
                if ($urandom_range(0, 1))
                    feed(CH_BSLASH);
                send_byte(8'($urandom), 1'b1, 1'b1, want);
            end
            E_STR_LONG:
            begin
                feed(CH_QUOTE);
                repeat (MAX_STRING_CHARS - 1) feed(text_byte());
                send_byte(text_byte(), 1'b0, 1'b1, want);
            end
            default:
            begin
                feed(word_byte(1'b1));
                repeat (MAX_IDENT_CHARS - 2) feed(word_byte(1'b0));
                send_byte(word_byte(1'b0), 1'b0, 1'b1, want);
            end
        endcase
        repeat (6) send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0, NO_TOK);
    endtask

    // ------------------------------------------------------------------------
    // token side
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        tok_stall = ($urandom_range(0, 99) < stall_pct);
    end

    function void report_mismatch(input string what, input tok_req_t want, input tok_req_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $display("%0t %s", $time, what);
            $display("  expected kind %0d num %0d char %02h len %0d err %0d last %0b",
                     want.token_kind, want.number_value, want.text_char, want.text_length,
                     want.error_code, want.last);
            $display("  actual   kind %0d num %0d char %02h len %0d err %0d last %0b",
                     got.token_kind, got.number_value, got.text_char, got.text_length,
                     got.error_code, got.last);
        end
    endfunction

    // every taken request is held against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && tok_valid && !tok_stall)
        begin
            if (tok_expected.size() == 0)
                report_mismatch("token request with nothing predicted", NO_TOK, tok_req);
            else
            begin
                tok_want = tok_expected.pop_front();
                if (tok_req.token_kind !== tok_want.token_kind
                    || tok_req.number_value !== tok_want.number_value
                    || tok_req.text_char !== tok_want.text_char
                    || tok_req.text_length !== tok_want.text_length
                    || tok_req.error_code !== tok_want.error_code
                    || tok_req.last !== tok_want.last)
                    report_mismatch("token request differs", tok_want, tok_req);
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        fatal_err     = ERR_W'($urandom_range(1, 3));
        random_budget = TOTAL_ITEMS - PROBE_COUNT - closing_cost(fatal_err);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < PROBE_COUNT; i++)
            send_byte(PROBE_ROWS[i].ch, PROBE_ROWS[i].fin, PROBE_ROWS[i].typed,
                      PROBE_ROWS[i].want);

        items_sent = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct  = PHASE_IDLE[phase];
            stall_pct = PHASE_STALL[phase];
            while (items_sent < (phase + 1) * random_budget / 4)
                random_token();
        end
        close_with_error(fatal_err);

        @(negedge clk);
        src_valid = 1'b0;
        while (tok_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: source_tokenizer_core.f
rtl/stok_pkg.sv
rtl/stok_lexer.sv
rtl/stok_result_queue.sv
rtl/source_tokenizer_core.sv
dv/source_tokenizer_core_test.sv
